// ----- design/p2m_pkg.sv -----
package p2m_pkg;

   localparam logic [1:0] OP_FALL        = 2'd0;
   localparam logic [1:0] OP_SEND        = 2'd1;
   localparam logic [1:0] OP_INHIBIT_END = 2'd2;

   localparam logic CSR_STREAM_MODE  = 1'b0;
   localparam logic CSR_PACKET_BYTES = 1'b1;

   localparam logic [3:0] DATA_BITS     = 4'd8;
   localparam logic [3:0] RX_PARITY_POS = 4'd9;
   localparam logic [3:0] RX_STOP_POS   = 4'd10;
   localparam logic [3:0] TX_PARITY_POS = 4'd9;
   localparam logic [3:0] TX_ACK_POS    = 4'd11;

   localparam logic [2:0] WHEEL_PACKET_BYTES = 3'd4;
   localparam logic [2:0] STD_PACKET_BYTES   = 3'd3;
   localparam logic [1:0] LAST_IDX_WHEEL     = 2'd3;
   localparam logic [1:0] LAST_IDX_STD       = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       parity_ok;
   } rx_event_type;

   typedef struct packed {
      logic clock_low;
      logic data_low;
      logic tx_done;
   } line_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] buttons;
      logic [7:0] move_x;
      logic [7:0] move_y;
      logic [7:0] wheel;
   } report_type;

   typedef struct packed {
      line_type     line;
      rx_event_type rx;
      report_type   report;
   } rsp_type;

endpackage

// ----- design/p2m_link.sv -----
module p2m_link
   import p2m_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [1:0]   opcode,
   input  logic         data_bit,
   input  logic [7:0]   cmd_byte,
   output line_type     line,
   output rx_event_type rx_event
);

   logic [3:0] bit_index_ff, bit_index_in;
   logic       receiving_ff, receiving_in;
   logic       sending_ff, sending_in;
   logic       inhibiting_ff, inhibiting_in;
   logic       send_pending_ff, send_pending_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [7:0] tx_latch_ff, tx_latch_in;
   logic       byte_parity_ff, byte_parity_in;
   logic [3:0] rx_pos;
   logic [3:0] tx_pos;

   assign rx_pos = bit_index_ff - 4'd1;

   always_comb begin
      bit_index_in    = bit_index_ff;
      receiving_in    = receiving_ff;
      sending_in      = sending_ff;
      inhibiting_in   = inhibiting_ff;
      send_pending_in = send_pending_ff;
      rx_shift_in     = rx_shift_ff;
      tx_latch_in     = tx_latch_ff;
      byte_parity_in  = byte_parity_ff;
      rx_event        = '0;
      line            = '0;
      case (opcode)
         OP_FALL: begin
            if (!inhibiting_ff) begin
               if (sending_ff) begin
                  bit_index_in = bit_index_ff + 4'd1;
                  if (bit_index_in >= TX_ACK_POS) begin
                     sending_in   = 1'b0;
                     bit_index_in = '0;
                     line.tx_done = 1'b1;
                  end
               end else if (bit_index_ff == '0) begin
                  rx_shift_in  = '0;
                  receiving_in = 1'b1;
                  bit_index_in = 4'd1;
               end else if (bit_index_ff < RX_PARITY_POS && receiving_ff) begin
                  rx_shift_in[rx_pos[2:0]] = rx_shift_ff[rx_pos[2:0]] | data_bit;
                  bit_index_in = bit_index_ff + 4'd1;
               end else if (bit_index_ff == RX_PARITY_POS) begin
                  byte_parity_in = (^rx_shift_ff) ^ data_bit;
                  bit_index_in   = bit_index_ff + 4'd1;
               end else begin
                  receiving_in       = 1'b0;
                  bit_index_in       = '0;
                  rx_event.valid     = 1'b1;
                  rx_event.data      = rx_shift_ff;
                  rx_event.parity_ok = byte_parity_ff;
                  if (send_pending_ff) begin
                     send_pending_in = 1'b0;
                     inhibiting_in   = 1'b1;
                  end
               end
            end
         end
         OP_SEND: begin
            if (!inhibiting_ff && !sending_ff && !send_pending_ff) begin
               tx_latch_in = cmd_byte;
               if (receiving_ff && bit_index_ff > RX_PARITY_POS) begin
                  send_pending_in = 1'b1;
               end else begin
                  inhibiting_in = 1'b1;
                  receiving_in  = 1'b0;
                  bit_index_in  = '0;
               end
            end
         end
         OP_INHIBIT_END: begin
            if (inhibiting_ff) begin
               inhibiting_in = 1'b0;
               sending_in    = 1'b1;
               bit_index_in  = '0;
            end
         end
         default: begin
         end
      endcase

      tx_pos         = bit_index_in - 4'd1;
      line.clock_low = inhibiting_in;
      if (sending_in && !inhibiting_in) begin
         if (bit_index_in == '0) begin
            line.data_low = 1'b1;
         end else if (bit_index_in <= DATA_BITS) begin
            line.data_low = ~tx_latch_in[tx_pos[2:0]];
         end else if (bit_index_in == TX_PARITY_POS) begin
            line.data_low = ^tx_latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_index_ff    <= '0;
         receiving_ff    <= 1'b0;
         sending_ff      <= 1'b0;
         inhibiting_ff   <= 1'b0;
         send_pending_ff <= 1'b0;
         rx_shift_ff     <= '0;
         tx_latch_ff     <= '0;
         byte_parity_ff  <= 1'b0;
      end else if (step) begin
         bit_index_ff    <= bit_index_in;
         receiving_ff    <= receiving_in;
         sending_ff      <= sending_in;
         inhibiting_ff   <= inhibiting_in;
         send_pending_ff <= send_pending_in;
         rx_shift_ff     <= rx_shift_in;
         tx_latch_ff     <= tx_latch_in;
         byte_parity_ff  <= byte_parity_in;
      end
   end

`ifndef ASSERT_OFF
   a_send_inhibit_excl: assert property (@(posedge clock) disable iff (reset)
      !(sending_ff && inhibiting_ff))
      else $error("sending and inhibiting together");

   a_pending_at_stop: assert property (@(posedge clock) disable iff (reset)
      send_pending_ff |-> (receiving_ff && bit_index_ff == RX_STOP_POS && !sending_ff))
      else $error("pending send outside the stop bit of a receive");

   a_inhibit_idle: assert property (@(posedge clock) disable iff (reset)
      inhibiting_ff |-> (bit_index_ff == '0 && !receiving_ff))
      else $error("bit counter or receive live during inhibit");
`endif

endmodule

// ----- design/p2m_packet.sv -----
module p2m_packet
   import p2m_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         stream_mode,
   input  logic [2:0]   packet_bytes,
   input  rx_event_type rx_event,
   output report_type   report
);

   logic [1:0] packet_index_ff, packet_index_in;
   logic       packet_parity_ff, packet_parity_in;
   logic [7:0] store_ff [0:2];
   logic       store_we;
   logic [1:0] store_addr;
   logic [1:0] last_index;
   logic       parity_next;
   logic [7:0] y_byte;
   logic [7:0] y_neg;

   assign last_index = (packet_bytes >= WHEEL_PACKET_BYTES) ? LAST_IDX_WHEEL : LAST_IDX_STD;
   assign y_byte     = (last_index == LAST_IDX_WHEEL) ? store_ff[2] : rx_event.data;
   assign y_neg      = (y_byte == 8'h80) ? 8'h7F : 8'(-y_byte);

   always_comb begin
      packet_index_in  = packet_index_ff;
      packet_parity_in = packet_parity_ff;
      parity_next      = packet_parity_ff & rx_event.parity_ok;
      store_we         = 1'b0;
      store_addr       = packet_index_ff;
      report           = '0;
      if (rx_event.valid) begin
         if (stream_mode) begin
            if (packet_index_ff < last_index) begin
               store_we         = 1'b1;
               packet_index_in  = packet_index_ff + 2'd1;
               packet_parity_in = parity_next;
            end else begin
               if (parity_next) begin
                  report.valid   = 1'b1;
                  report.buttons = store_ff[0][2:0];
                  report.move_x  = store_ff[1];
                  report.move_y  = y_neg;
                  report.wheel   = (last_index == LAST_IDX_WHEEL) ? rx_event.data : 8'h00;
               end
               packet_index_in  = '0;
               packet_parity_in = 1'b1;
            end
         end else begin
            packet_index_in  = '0;
            packet_parity_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_index_ff  <= '0;
         packet_parity_ff <= 1'b1;
      end else if (step) begin
         packet_index_ff  <= packet_index_in;
         packet_parity_ff <= packet_parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && store_we) begin
         store_ff[store_addr] <= rx_event.data;
      end
   end

endmodule

// ----- design/ps2_host_mouse_link.sv -----
// PS/2 host link engine with mouse packet assembly.
// req_ channel: one line event per item. req_opcode selects a device clock
// falling edge (req_data_bit is the sampled data level), a send request
// (req_cmd_byte is the command) or the end of the clock-inhibit time.
// rsp_ channel: exactly one item per request, carrying the host line drives
// after the event, the received byte with its parity check at a stop bit,
// the acknowledge pulse of a sent frame, and a decoded mouse report on the
// last byte of a packet with good parity on every byte, in stream mode.
// csr_ port: index 0 enables stream mode, index 1 sets bytes per packet
// (3, or 4 for a wheel mouse); write only while no item is in flight.
// An accepted item waits in the input register; its result is registered into
// the result register on rsp_. Throughput: one item per cycle while results are
// taken, the state update being one combinational pass between those registers.
// Reset clears the link state, the packet counter and the configuration
// (stream mode off, 3-byte packets); both channels come up empty.
// When rsp_ready is low the result holds, one further item waits in the input
// register, and req_ready then drops until the result is taken.
module ps2_host_mouse_link
   import p2m_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic              req_data_bit,
   input  logic [7:0]        req_cmd_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_clock_drive_low,
   output logic              rsp_data_drive_low,
   output logic              rsp_rx_valid,
   output logic [7:0]        rsp_rx_byte,
   output logic              rsp_parity_ok,
   output logic              rsp_tx_done,
   output logic              rsp_report_valid,
   output logic [2:0]        rsp_buttons,
   output logic signed [7:0] rsp_move_x,
   output logic signed [7:0] rsp_move_y,
   output logic signed [7:0] rsp_wheel,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [2:0]        csr_wdata
);

   logic         in_valid_ff, in_valid_in;
   logic [1:0]   opcode_ff, opcode_in;
   logic         data_bit_ff, data_bit_in;
   logic [7:0]   cmd_byte_ff, cmd_byte_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;
   logic         stream_mode_ff, stream_mode_in;
   logic [2:0]   packet_bytes_ff, packet_bytes_in;
   logic         advance;
   logic         req_fire;
   line_type     line;
   rx_event_type rx_event;
   report_type   report;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      opcode_in   = opcode_ff;
      data_bit_in = data_bit_ff;
      cmd_byte_in = cmd_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         opcode_in   = req_opcode;
         data_bit_in = req_data_bit;
         cmd_byte_in = req_cmd_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in  = 1'b1;
         rsp_in.line   = line;
         rsp_in.rx     = rx_event;
         rsp_in.report = report;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      stream_mode_in  = stream_mode_ff;
      packet_bytes_in = packet_bytes_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_STREAM_MODE:  stream_mode_in  = csr_wdata[0];
            CSR_PACKET_BYTES: packet_bytes_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         stream_mode_ff  <= 1'b0;
         packet_bytes_ff <= STD_PACKET_BYTES;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         stream_mode_ff  <= stream_mode_in;
         packet_bytes_ff <= packet_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      data_bit_ff <= data_bit_in;
      cmd_byte_ff <= cmd_byte_in;
      rsp_ff      <= rsp_in;
   end

   p2m_link u_link (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .opcode   (opcode_ff),
      .data_bit (data_bit_ff),
      .cmd_byte (cmd_byte_ff),
      .line     (line),
      .rx_event (rx_event)
   );

   p2m_packet u_packet (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .stream_mode  (stream_mode_ff),
      .packet_bytes (packet_bytes_ff),
      .rx_event     (rx_event),
      .report       (report)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_clock_drive_low = rsp_ff.line.clock_low;
   assign rsp_data_drive_low  = rsp_ff.line.data_low;
   assign rsp_tx_done         = rsp_ff.line.tx_done;
   assign rsp_rx_valid        = rsp_ff.rx.valid;
   assign rsp_rx_byte         = rsp_ff.rx.data;
   assign rsp_parity_ok       = rsp_ff.rx.parity_ok;
   assign rsp_report_valid    = rsp_ff.report.valid;
   assign rsp_buttons         = rsp_ff.report.buttons;
   assign rsp_move_x          = $signed(rsp_ff.report.move_x);
   assign rsp_move_y          = $signed(rsp_ff.report.move_y);
   assign rsp_wheel           = $signed(rsp_ff.report.wheel);

`ifndef ASSERT_OFF
   a_report_needs_good_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.report.valid) |-> (rsp_ff.rx.valid && rsp_ff.rx.parity_ok))
      else $error("report without a good received byte");

   a_rx_tx_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.rx.valid && rsp_ff.line.tx_done))
      else $error("receive and send completed by one item");
`endif

endmodule
